// ===== design/cprq_pkg.sv =====
// Shared types and constants for the coalescing pointer report queue.
package cprq_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] FUNC_REPORT   = 2'd0;
    localparam logic [1:0] FUNC_ACTIVITY = 2'd1;
    localparam logic [1:0] FUNC_POLL     = 2'd2;
    localparam logic [1:0] FUNC_TICK     = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2500;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  buttons;
        logic [15:0] x;
        logic [15:0] y;
    } t_rep;

endpackage

// ===== design/cprq_store.sv =====
// Report storage: one write port, one read port with registered read data.
module cprq_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  cprq_pkg::t_rep  i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output cprq_pkg::t_rep  o_rd_data
);

    cprq_pkg::t_rep r_mem [DEPTH];
    cprq_pkg::t_rep r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a shared address; the ports never need the new data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/coalescing_pointer_report_queue_unit.sv =====
// Top level of the coalescing pointer report queue.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// a pointer report, other link activity, a service poll or a 1 ms tick.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item, in order: the presented head report (on polls), overflow and
// automatic-release flags, the entry count and the in-flight flag.
// Config channel (i_cfg_valid / o_cfg_ready) writes release_timeout_ms;
// it is always ready and should only be written while the block is idle.
// Timing: the item sits in the input register, where the whole queue
// update runs as one pass of logic; the result register loads when the
// item advances, with the head read from the storage's registered read port.
// Throughput is one item per cycle while the result channel is not stalled.
// Reset: synchronous, active low. Queue empty, nothing in flight, last report
// and idle counter zero, timeout 2500. Storage is not cleared; only written
// slots are ever presented.
// Stall: a stalled result holds; the input register holds behind it and the
// input stall rises, so nothing is dropped or repeated.
module coalescing_pointer_report_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [7:0]                         i_report_buttons,
    input  logic [15:0]                        i_report_x,
    input  logic [15:0]                        i_report_y,
    input  logic                               i_usb_configured,
    input  logic                               i_endpoint_idle,
    input  logic                               i_send_accepted,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_send_valid,
    output logic [7:0]                         o_send_buttons,
    output logic [15:0]                        o_send_x,
    output logic [15:0]                        o_send_y,
    output logic                               o_overflow,
    output logic                               o_released,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_queue_count,
    output logic                               o_head_in_flight,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [15:0]                        i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    // ---------------------------------------------------------------
    // Queue state
    // ---------------------------------------------------------------
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic            r_infl;
    cprq_pkg::t_rep  r_last;      // last desired report; also the tail's buttons
    logic [15:0]     r_idle;
    logic [15:0]     r_timeout;

    logic [AW-1:0]   n_head;
    logic [CW-1:0]   n_count;
    logic            n_infl;
    cprq_pkg::t_rep  n_last;
    logic [15:0]     n_idle;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic            r_s1_valid;
    logic [1:0]      r_s1_func;
    cprq_pkg::t_rep  r_s1_rep;
    logic            r_s1_cfg;
    logic            r_s1_ep_idle;
    logic            r_s1_acc;

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic            r_out_valid;
    logic            r_out_sv;
    logic            r_out_ovf;
    logic            r_out_rel;
    logic [CW-1:0]   r_out_count;
    logic            r_out_infl;

    logic            adv;
    logic            in_xfer;

    // Advance the input register into the result register when the result
    // slot is empty or is being taken this cycle.
    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Ring slot arithmetic
    // ---------------------------------------------------------------
    logic [SW-1:0]  app_sum;
    logic [SW-1:0]  tail_sum;
    logic [AW-1:0]  app_slot;
    logic [AW-1:0]  tail_slot;
    logic [AW-1:0]  head_inc;

    always_comb begin
        app_sum  = SW'(r_head) + SW'(r_count);
        tail_sum = app_sum - SW'(1);
        app_slot  = (app_sum >= DEPTH_S) ? AW'(app_sum - DEPTH_S) : AW'(app_sum);
        tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        head_inc  = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    end

    // ---------------------------------------------------------------
    // Single-pass update for the item in the input register
    // ---------------------------------------------------------------
    logic            do_push;
    cprq_pkg::t_rep  push_rep;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   pop_head;
    logic [CW-1:0]   pop_count;
    logic [15:0]     idle_inc;
    logic            sv;
    logic            ovf;
    logic            rel;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_infl    = r_infl;
        n_last    = r_last;
        n_idle    = r_idle;
        do_push   = 1'b0;
        push_rep  = r_s1_rep;
        wr_en     = 1'b0;
        wr_addr   = tail_slot;
        rd_addr   = r_head;
        pop_head  = r_head;
        pop_count = r_count;
        idle_inc  = (r_idle == cprq_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;
        sv        = 1'b0;
        ovf       = 1'b0;
        rel       = 1'b0;

        case (r_s1_func)
            cprq_pkg::FUNC_REPORT: begin
                do_push = 1'b1;
                n_idle  = '0;
            end
            cprq_pkg::FUNC_ACTIVITY: begin
                n_idle = '0;
            end
            cprq_pkg::FUNC_POLL: begin
                if (!r_s1_cfg) begin
                    // link down: drop the whole queue, keep the idle count
                    n_head  = '0;
                    n_count = '0;
                    n_infl  = 1'b0;
                    n_last  = '0;
                end else if (!(r_infl && !r_s1_ep_idle)) begin
                    // pop the head that finished sending
                    if (r_infl) begin
                        if (r_count != '0) begin
                            pop_head  = head_inc;
                            pop_count = r_count - CW'(1);
                        end
                        n_infl = 1'b0;
                    end
                    n_head  = pop_head;
                    n_count = pop_count;
                    rd_addr = pop_head;
                    if (pop_count != '0) begin
                        sv = 1'b1;
                        if (r_s1_acc) begin
                            n_infl = 1'b1;
                        end
                    end
                end
            end
            cprq_pkg::FUNC_TICK: begin
                n_idle = idle_inc;
                if (r_last.buttons != '0 && idle_inc > r_timeout) begin
                    // auto release at the last coordinate
                    do_push  = 1'b1;
                    push_rep = '{buttons: 8'd0, x: r_last.x, y: r_last.y};
                    rel      = 1'b1;
                    n_idle   = '0;
                end
            end
            default: begin
            end
        endcase

        if (do_push) begin
            n_last = push_rep;
            // coalesce into the tail when buttons match and it is not on the wire
            if (r_count != '0 && !(r_infl && r_count == CW'(1))
                    && r_last.buttons == push_rep.buttons) begin
                wr_en   = 1'b1;
                wr_addr = tail_slot;
            end else if (r_count != DEPTH_C) begin
                wr_en   = 1'b1;
                wr_addr = app_slot;
                n_count = r_count + CW'(1);
            end else begin
                wr_en   = 1'b1;
                wr_addr = tail_slot;
                ovf     = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Report storage
    // ---------------------------------------------------------------
    cprq_pkg::t_rep rd_data;

    cprq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && adv),
        .i_wr_addr (wr_addr),
        .i_wr_data (push_rep),
        .i_rd_en   (adv),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_xfer || (r_s1_valid && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func    <= i_func;
            r_s1_rep     <= '{buttons: i_report_buttons, x: i_report_x, y: i_report_y};
            r_s1_cfg     <= i_usb_configured;
            r_s1_ep_idle <= i_endpoint_idle;
            r_s1_acc     <= i_send_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_infl  <= 1'b0;
            r_last  <= '0;
            r_idle  <= '0;
        end else if (adv) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_infl  <= n_infl;
            r_last  <= n_last;
            r_idle  <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= cprq_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= adv || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sv    <= sv;
            r_out_ovf   <= ovf;
            r_out_rel   <= rel;
            r_out_count <= n_count;
            r_out_infl  <= n_infl;
        end
    end

    // ---------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------
    assign o_out_valid      = r_out_valid;
    assign o_send_valid     = r_out_sv;
    assign o_send_buttons   = r_out_sv ? rd_data.buttons : 8'd0;
    assign o_send_x         = r_out_sv ? rd_data.x : 16'd0;
    assign o_send_y         = r_out_sv ? rd_data.y : 16'd0;
    assign o_overflow       = r_out_ovf;
    assign o_released       = r_out_rel;
    assign o_queue_count    = r_out_count;
    assign o_head_in_flight = r_out_infl;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the coalescing pointer report queue unit.
`timescale 1ns / 1ps

module tb;

    localparam int QDEPTH     = 32;
    localparam int PHASE_ITEMS = 170;
    localparam int STALL_LIMIT = 1000;

    // One input transfer: item kind plus every payload field
    typedef struct packed {
        logic [1:0]     func;
        cprq_pkg::t_rep rep;
        logic           configured;
        logic           ep_idle;
        logic           accepted;
    } t_item;

    // One result transfer
    typedef struct packed {
        logic           present;
        cprq_pkg::t_rep rep;
        logic           ovf;
        logic           rel;
        logic [5:0]     count;
        logic           busy;
    } t_outcome;

    // Mirror of the queue state; predicts one outcome per accepted item
    class pointer_queue_tracker;
        cprq_pkg::t_rep store[QDEPTH];
        int unsigned    head;
        int unsigned    count;
        bit             in_flight;
        cprq_pkg::t_rep last_rep = '0;
        logic [15:0]    idle_ms = '0;
        logic [15:0]    release_ms = cprq_pkg::TIMEOUT_RESET;
        t_outcome       pending[$];
        int             mismatches;

        // Coalesce into the tail, append, or overwrite the last slot when full
        function bit queue_report(cprq_pkg::t_rep r);
            int unsigned tail;
            last_rep = r;
            if (count > 0) begin
                tail = (head + count - 1) % QDEPTH;
                if (!(in_flight && count == 1) && store[tail].buttons == r.buttons) begin
                    store[tail] = r;
                    return 1'b0;
                end
            end
            if (count < QDEPTH) begin
                store[(head + count) % QDEPTH] = r;
                count++;
                return 1'b0;
            end
            store[(head + QDEPTH - 1) % QDEPTH] = r;
            return 1'b1;
        endfunction

        function void note_item(t_item it);
            t_outcome       o;
            cprq_pkg::t_rep r;
            o = '0;
            case (it.func)
                cprq_pkg::FUNC_REPORT: begin
                    idle_ms = '0;
                    o.ovf   = queue_report(it.rep);
                end
                cprq_pkg::FUNC_ACTIVITY: idle_ms = '0;
                cprq_pkg::FUNC_POLL: begin
                    if (!it.configured) begin
                        // link down: drop the queue, keep the idle count
                        head      = 0;
                        count     = 0;
                        in_flight = 1'b0;
                        last_rep  = '0;
                    end else if (!(in_flight && !it.ep_idle)) begin
                        // endpoint done: retire the head that was sent
                        if (in_flight) begin
                            if (count > 0) begin
                                head = (head + 1) % QDEPTH;
                                count--;
                            end
                            in_flight = 1'b0;
                        end
                        if (count > 0) begin
                            o.present = 1'b1;
                            o.rep     = store[head];
                            if (it.accepted) in_flight = 1'b1;
                        end
                    end
                end
                default: begin
                    if (idle_ms != cprq_pkg::IDLE_MAX) idle_ms++;
                    if (last_rep.buttons != '0 && idle_ms > release_ms) begin
                        r         = last_rep;
                        r.buttons = '0;
                        o.ovf     = queue_report(r);
                        o.rel     = 1'b1;
                        idle_ms   = '0;
                    end
                end
            endcase
            o.count = 6'(count);
            o.busy  = in_flight;
            pending.push_back(o);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t  %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t  unexpected result: expected none, actual 0x%0h", $time, got);
                return;
            end
            want = pending.pop_front();
            compare("send_valid", want.present, got.present);
            compare("send_buttons", want.rep.buttons, got.rep.buttons);
            compare("send_x", want.rep.x, got.rep.x);
            compare("send_y", want.rep.y, got.rep.y);
            compare("overflow", want.ovf, got.ovf);
            compare("released", want.rel, got.rel);
            compare("queue_count", want.count, got.count);
            compare("head_in_flight", want.busy, got.busy);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [7:0]  i_report_buttons;
    logic [15:0] i_report_x;
    logic [15:0] i_report_y;
    logic        i_usb_configured;
    logic        i_endpoint_idle;
    logic        i_send_accepted;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_send_valid;
    logic [7:0]  o_send_buttons;
    logic [15:0] o_send_x;
    logic [15:0] o_send_y;
    logic        o_overflow;
    logic        o_released;
    logic [5:0]  o_queue_count;
    logic        o_head_in_flight;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    pointer_queue_tracker tracker;
    bit                   quiet;        // no idling on either side while set
    int                   items_sent;
    int                   no_xfer_cycles;
    logic [7:0]           last_buttons;

    coalescing_pointer_report_queue_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_report_buttons(i_report_buttons),
        .i_report_x      (i_report_x),
        .i_report_y      (i_report_y),
        .i_usb_configured(i_usb_configured),
        .i_endpoint_idle (i_endpoint_idle),
        .i_send_accepted (i_send_accepted),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_send_valid    (o_send_valid),
        .o_send_buttons  (o_send_buttons),
        .o_send_x        (o_send_x),
        .o_send_y        (o_send_y),
        .o_overflow      (o_overflow),
        .o_released      (o_released),
        .o_queue_count   (o_queue_count),
        .o_head_in_flight(o_head_in_flight),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    // Random content in every field; callers overwrite what the item kind uses
    function t_item scrambled_item();
        t_item it;
        it.func        = 2'($urandom_range(0, 3));
        it.rep.buttons = 8'($urandom_range(0, 255));
        it.rep.x       = 16'($urandom_range(0, 65535));
        it.rep.y       = 16'($urandom_range(0, 65535));
        it.configured  = 1'($urandom_range(0, 1));
        it.ep_idle     = 1'($urandom_range(0, 1));
        it.accepted    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function logic [7:0] pick_buttons();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold off a random number of cycles, present the item, wait for the transfer
    task send_item(t_item it);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func           = it.func;
        i_report_buttons = it.rep.buttons;
        i_report_x       = it.rep.x;
        i_report_y       = it.rep.y;
        i_usb_configured = it.configured;
        i_endpoint_idle  = it.ep_idle;
        i_send_accepted  = it.accepted;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(it);
        items_sent++;
    endtask

    task send_report(logic [7:0] b, logic [15:0] x, logic [15:0] y);
        t_item it;
        it             = scrambled_item();
        it.func        = cprq_pkg::FUNC_REPORT;
        it.rep.buttons = b;
        it.rep.x       = x;
        it.rep.y       = y;
        send_item(it);
    endtask

    task send_poll(logic cfgd, logic ep_idle, logic acc);
        t_item it;
        it            = scrambled_item();
        it.func       = cprq_pkg::FUNC_POLL;
        it.configured = cfgd;
        it.ep_idle    = ep_idle;
        it.accepted   = acc;
        send_item(it);
    endtask

    task send_func(logic [1:0] f);
        t_item it;
        it      = scrambled_item();
        it.func = f;
        send_item(it);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_timeout(logic [15:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.release_ms = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task random_burst(logic [15:0] timeout);
        int n;
        int ticks;
        quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                // change the mask every time so each report appends; may overflow the queue
                n = $urandom_range(30, 40);
                repeat (n) begin
                    last_buttons = last_buttons ^ 8'($urandom_range(1, 255));
                    send_report(last_buttons, 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)));
                end
            end
            2, 3: begin
                // drain: mostly configured polls with an idle endpoint
                n = $urandom_range(10, 40);
                repeat (n) send_poll($urandom_range(0, 29) != 0, $urandom_range(0, 4) != 0,
                                     $urandom_range(0, 9) < 7);
            end
            4, 5: begin
                // hold buttons, then tick up to or past the timeout when it is short
                send_report(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
                ticks = (timeout <= 20) ? int'(timeout) + $urandom_range(0, 3)
                                        : $urandom_range(1, 10);
                repeat (ticks) send_func(cprq_pkg::FUNC_TICK);
                if ($urandom_range(0, 1) == 0) send_func(cprq_pkg::FUNC_ACTIVITY);
            end
            6, 7, 8: begin
                n = $urandom_range(5, 20);
                repeat (n) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: send_report(pick_buttons(),
                                                16'($urandom_range(0, 65535)),
                                                16'($urandom_range(0, 65535)));
                        4, 5, 6: send_poll($urandom_range(0, 19) != 0,
                                           $urandom_range(0, 9) < 7,
                                           $urandom_range(0, 9) < 6);
                        7, 8: send_func(cprq_pkg::FUNC_TICK);
                        default: send_func(cprq_pkg::FUNC_ACTIVITY);
                    endcase
                end
            end
            default: begin
                // noise: every field random, every kind
                repeat (10) send_item(scrambled_item());
            end
        endcase
    endtask

    // Result side: draw a stall length per result, then take one transfer
    initial begin
        int gap;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.present     = o_send_valid;
            got.rep.buttons = o_send_buttons;
            got.rep.x       = o_send_x;
            got.rep.y       = o_send_y;
            got.ovf         = o_overflow;
            got.rel         = o_released;
            got.count       = o_queue_count;
            got.busy        = o_head_in_flight;
            tracker.check_result(got);
        end
    end

    // Watchdog: count cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                no_xfer_cycles = 0;
            end else begin
                no_xfer_cycles++;
            end
            if (no_xfer_cycles >= STALL_LIMIT) begin
                $display("%0t  watchdog: no transfer for %0d cycles", $time, no_xfer_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] settings[5];
        int          phase_start;
        settings = '{16'd3, 16'hFFFF, 16'd1, 16'd9, 16'd2500};

        tracker          = new;
        quiet            = 1'b0;
        items_sent       = 0;
        no_xfer_cycles   = 0;
        last_buttons     = 8'h00;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = cprq_pkg::FUNC_ACTIVITY;
        i_report_buttons = '0;
        i_report_x       = '0;
        i_report_y       = '0;
        i_usb_configured = 1'b0;
        i_endpoint_idle  = 1'b0;
        i_send_accepted  = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pass with the shortest timeout
        write_timeout(16'd1);
        send_poll(1'b1, 1'b1, 1'b1);                  // empty queue: nothing presented
        send_report(8'h00, 16'h0000, 16'h0000);
        send_report(8'h00, 16'hFFFF, 16'hFFFF);       // same mask: coalesce into tail
        send_report(8'hFF, 16'h1234, 16'h5678);       // new mask: append
        send_report(8'hFF, 16'hFFFF, 16'h0000);
        send_poll(1'b1, 1'b0, 1'b0);                  // refused send: head stays
        send_poll(1'b1, 1'b0, 1'b1);                  // accepted: head in flight
        send_poll(1'b1, 1'b0, 1'b1);                  // busy endpoint: no change
        send_poll(1'b1, 1'b1, 1'b1);                  // pop, present next head
        send_report(8'hFF, 16'h0005, 16'h0006);       // tail in flight: append
        send_func(cprq_pkg::FUNC_ACTIVITY);
        send_func(cprq_pkg::FUNC_TICK);
        send_func(cprq_pkg::FUNC_TICK);               // past timeout: release queued
        send_func(cprq_pkg::FUNC_TICK);               // buttons already clear
        send_poll(1'b0, 1'b1, 1'b1);                  // link down: clear
        send_poll(1'b1, 1'b1, 1'b1);
        send_report(8'h80, 16'hFFFF, 16'hFFFF);
        send_func(cprq_pkg::FUNC_TICK);
        send_func(cprq_pkg::FUNC_TICK);
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b1);
        send_poll(1'b1, 1'b1, 1'b1);

        // Random phases, one timeout setting each
        foreach (settings[p]) begin
            write_timeout(settings[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_burst(settings[p]);
        end

        wait_drained();
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
